// ----- hdl/htbs_pkg.sv -----
package htbs_pkg;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // register index = paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_BYTE_SWAP   = 1'b1;

  localparam int COUNT_W = 11;
  localparam int ID_W    = 10;
  localparam int WORD_W  = 32;
  localparam int REC_W   = 3 * WORD_W;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   entry_index;
    logic [WORD_W-1:0] hash_value;
    logic [WORD_W-1:0] start_word;
    logic [WORD_W-1:0] end_word;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   hit_index;
    logic [WORD_W-1:0] data_offset;
    logic [WORD_W-1:0] data_length;
    logic              range_error;
  } out_item_t;

  function automatic logic [WORD_W-1:0] to_host(input logic [WORD_W-1:0] w,
                                                input logic swap);
    logic [WORD_W-1:0] r;
    r = swap ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    return r;
  endfunction

endpackage

// ----- hdl/hash_table_binary_search_lookup_core.sv -----
// Channel | Dir | Handshake               | Payload
// in_     | in  | in_valid / in_stall     | htbs_pkg::in_item_t  (load or lookup)
// out_    | out | out_valid / out_stall   | htbs_pkg::out_item_t (one per lookup)
// cfg     | in  | APB psel/penable/pwrite | entry_count @0x0, byte_swap @0x4
//
// A load with an index below ENTRIES writes its record into the record memory. A lookup
// probes the single record memory read port up to 12 times at 1024 entries, each probe
// an address step then a compare step, and then moves the result into the output register.
// Reset clears the sequencer, the output valid and both config registers; the
// record memory is not cleared. in_stall is high while a lookup is in flight;
// a stalled output holds its result and the sequencer waits in its last state.
module hash_table_binary_search_lookup_core #(
  parameter int ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output htbs_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int W     = htbs_pkg::WORD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [htbs_pkg::COUNT_W-1:0] entry_count_r;
  logic                         byte_swap_r;

  logic [1:0]       state_r, state_nxt;
  logic [W-1:0]     key_r, key_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  htbs_pkg::out_item_t out_r, out_nxt;

  logic [htbs_pkg::REC_W-1:0] rec_mem [ENTRIES];
  logic [htbs_pkg::REC_W-1:0] rec_rd_r;

  logic             in_acc;
  logic             mem_we;
  logic             cfg_we;
  logic [CNT_W-1:0] n_clamp;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_c;
  logic [W-1:0]     rd_hash;
  logic [W-1:0]     rd_start;
  logic [W-1:0]     rd_end;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == htbs_pkg::REG_ENTRY_COUNT) ?
                     {{(32-htbs_pkg::COUNT_W){1'b0}}, entry_count_r} :
                     {31'd0, byte_swap_r};

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign mem_we    = in_acc && (in_data.func == htbs_pkg::FUNC_LOAD) &&
                     (int'(in_data.entry_index) < ENTRIES);
  assign n_clamp   = (int'(entry_count_r) > ENTRIES) ? CNT_W'(ENTRIES) :
                     CNT_W'(entry_count_r);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = mid_sum[CNT_W:1];

  assign rd_hash   = htbs_pkg::to_host(rec_rd_r[3*W-1:2*W], byte_swap_r);
  assign rd_start  = htbs_pkg::to_host(rec_rd_r[2*W-1:W], byte_swap_r);
  assign rd_end    = htbs_pkg::to_host(rec_rd_r[W-1:0], byte_swap_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    n_nxt         = n_r;
    hit_nxt       = hit_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.func == htbs_pkg::FUNC_LOOKUP)) begin
          key_nxt   = in_data.hash_value;
          lo_nxt    = '0;
          hi_nxt    = n_clamp;
          n_nxt     = n_clamp;
          hit_nxt   = 1'b0;
          state_nxt = (n_clamp == '0) ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        mid_nxt   = mid_c;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_hash == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (rd_hash < key_r) begin
          if (lo_r == mid_r) begin
            state_nxt = S_FIN;
          end else begin
            lo_nxt    = mid_r;
            state_nxt = S_READ;
          end
        end else begin
          if (hi_r == mid_r) begin
            state_nxt = S_FIN;
          end else begin
            hi_nxt    = mid_r;
            state_nxt = S_READ;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (hit_r) begin
            out_nxt.found       = 1'b1;
            out_nxt.hit_index   = htbs_pkg::ID_W'(mid_r);
            out_nxt.data_offset = rd_start;
            if (rd_start > rd_end) begin
              out_nxt.range_error = 1'b1;
            end else begin
              out_nxt.data_length = rd_end - rd_start;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
      byte_swap_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (paddr[2] == htbs_pkg::REG_ENTRY_COUNT) begin
          entry_count_r <= pwdata[htbs_pkg::COUNT_W-1:0];
        end else begin
          byte_swap_r <= pwdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    n_r   <= n_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end

  // record memory: one write port (loads), one registered read port (probes)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_mem[IDX_W'(in_data.entry_index)] <=
        {in_data.hash_value, in_data.start_word, in_data.end_word};
    end
    if (state_r == S_READ) begin
      rec_rd_r <= rec_mem[mid_c[IDX_W-1:0]];
    end
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r < n_r) && (lo_r <= hi_r))
    else $error("probe index outside the searched range");

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.func == htbs_pkg::FUNC_LOOKUP)) |=> (state_r != S_IDLE))
    else $error("lookup transfer did not start the search");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result presented without finishing a search");

  a_load_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (state_r == S_IDLE))
    else $error("load transfer left the idle state");

endmodule
